// ===== src/dvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance-vector router package
// Shared widths, codes, reset values and the control bundle that the
// sequencer hands to the relaxation unit.
// ----------------------------------------------------------------------------
package dvr_pkg;

   localparam int IDX_W   = 3;
   localparam int COST_W  = 9;
   localparam int HOP_W   = 4;
   localparam int SUM_W   = 10;
   localparam int CSR_W   = 3;
   localparam int CSR_IW  = 1;

   localparam int COST_CAP = 128;

   localparam logic signed [COST_W-1:0] NO_ROUTE = -9'sd1;
   localparam logic signed [HOP_W-1:0]  NO_HOP   = -4'sd1;

   localparam logic KIND_LINK   = 1'b0;
   localparam logic KIND_VECTOR = 1'b1;

   localparam logic [CSR_IW-1:0] CSR_SELF_INDEX = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_RECOMPUTE  = 1'b1;

   typedef struct packed {
      logic             step;
      logic             first;
      logic             skip;
      logic             diag;
      logic [IDX_W-1:0] hop;
   } relax_ctl_type;

endpackage

// ===== src/dvr_cost_mem.sv =====
// ----------------------------------------------------------------------------
// Cost table memory
// One write port and two registered read ports; entries never written since
// reset read as unreachable through a per-entry valid bit.
// ----------------------------------------------------------------------------
module dvr_cost_mem
   import dvr_pkg::*;
#(
   parameter int AW = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [COST_W-1:0] wr_data,
   input  logic [AW-1:0]            rd_addr_a,
   input  logic [AW-1:0]            rd_addr_b,
   output logic signed [COST_W-1:0] rd_data_a,
   output logic signed [COST_W-1:0] rd_data_b
);

   localparam int DEPTH = 1 << AW;

   logic signed [COST_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]         valid_ff;
   logic [DEPTH-1:0]         valid_in;
   logic signed [COST_W-1:0] data_a_ff;
   logic signed [COST_W-1:0] data_b_ff;
   logic                     vld_a_ff;
   logic                     vld_b_ff;

   // Reset clears every valid bit; a write in the same cycle marks its entry.
   always_comb begin
      valid_in = reset ? '0 : valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_a_ff <= mem[rd_addr_a];
      data_b_ff <= mem[rd_addr_b];
      vld_a_ff  <= valid_ff[rd_addr_a];
      vld_b_ff  <= valid_ff[rd_addr_b];
   end

   assign rd_data_a = vld_a_ff ? data_a_ff : NO_ROUTE;
   assign rd_data_b = vld_b_ff ? data_b_ff : NO_ROUTE;

endmodule

// ===== src/dvr_relax_unit.sv =====
// ----------------------------------------------------------------------------
// Relaxation unit
// Adds one link cost to one advertised cost, drops a sum above the cap and
// keeps the running minimum and its hop over the hops of one destination.
// ----------------------------------------------------------------------------
module dvr_relax_unit
   import dvr_pkg::*;
(
   input  logic                     clock,
   input  relax_ctl_type            ctl,
   input  logic signed [COST_W-1:0] link_cost,
   input  logic signed [COST_W-1:0] far_cost,
   output logic signed [COST_W-1:0] best_cost,
   output logic [IDX_W-1:0]         best_hop
);

   logic signed [COST_W-1:0] best_ff;
   logic [IDX_W-1:0]         hop_ff;
   logic signed [COST_W-1:0] far_eff;
   logic signed [COST_W-1:0] base_cost;
   logic [IDX_W-1:0]         base_hop;
   logic [SUM_W-1:0]         sum;
   logic                     cand_ok;
   logic                     take;

   always_comb begin
      // The advertised cost of a hop to itself is zero by definition.
      far_eff   = ctl.diag ? '0 : far_cost;
      sum       = {2'b00, link_cost[COST_W-2:0]} + {2'b00, far_eff[COST_W-2:0]};
      cand_ok   = !ctl.skip && !link_cost[COST_W-1] && !far_eff[COST_W-1]
                  && (sum <= SUM_W'(COST_CAP));
      base_cost = ctl.first ? NO_ROUTE : best_ff;
      base_hop  = ctl.first ? '0 : hop_ff;
      // Strictly lower wins, so ties stay with the lower hop seen first.
      take      = cand_ok && (base_cost[COST_W-1] || (sum < {1'b0, base_cost}));
      best_cost = take ? COST_W'(sum) : base_cost;
      best_hop  = take ? ctl.hop : base_hop;
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         best_ff <= best_cost;
         hop_ff  <= best_hop;
      end
   end

endmodule

// ===== src/distance_vector_router_node.sv =====
// ----------------------------------------------------------------------------
// Distance-vector router node
// Bellman-Ford route table of one node with poison-reverse advertisement.
// ----------------------------------------------------------------------------
// A request transaction is taken at a rising edge with start high and busy
// low. It is either a link-cost change to a neighbour or one entry of a
// vector that a neighbour advertised; a negative cost is stored as
// unreachable. A link change (when recompute is enabled) or the final entry
// of a vector starts a recompute; any other request is absorbed in its own
// cycle and busy never rises.
// The recompute walks every destination and every hop through one shared
// add-and-compare unit, one pair per cycle, reading two cost-table entries
// each cycle. If any path cost changed, the node then sends its vector to
// every live neighbour: NODES response transactions per live neighbour,
// one per cycle, and none to a node that is not a live neighbour.
// rsp_last marks the final response.
// Responses appear on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall them. Busy falls once the last node has
// been visited, which can already be the cycle that carries the final one.
// Reset is synchronous: the cost table reads unreachable everywhere except
// the self entry, the node number is zero and recompute on link is enabled.
// Configuration writes are taken at any edge with csr_write high and are
// only expected while busy is low.
// ----------------------------------------------------------------------------
module distance_vector_router_node
   import dvr_pkg::*;
#(
   parameter int NODES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_kind,
   input  logic [IDX_W-1:0]         req_neighbor,
   input  logic [IDX_W-1:0]         req_entry_dest,
   input  logic signed [COST_W-1:0] req_cost,
   input  logic                     req_last_entry,
   output logic                     rsp_valid,
   output logic [IDX_W-1:0]         rsp_to_neighbor,
   output logic [IDX_W-1:0]         rsp_adv_dest,
   output logic signed [COST_W-1:0] rsp_adv_cost,
   output logic signed [HOP_W-1:0]  rsp_next_hop,
   output logic signed [COST_W-1:0] rsp_path_cost,
   output logic                     rsp_last,
   input  logic                     csr_write,
   input  logic [CSR_IW-1:0]        csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int AW = 2 * IW;
   localparam logic [IDX_W:0]  NODE_LIM = (IDX_W + 1)'(NODES);
   localparam logic [IW-1:0]   LAST_IDX = IW'(NODES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEND
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         self_ff, self_in;
   logic                     recompute_ff, recompute_in;
   logic [IW-1:0]            d_ff, d_in;
   logic [IW-1:0]            h_ff, h_in;
   logic                     issue_ff, issue_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic [IW-1:0]            s1_d_ff, s1_d_in;
   logic [IW-1:0]            s1_h_ff, s1_h_in;
   logic                     changed_ff, changed_in;
   logic [NODES-1:0]         live_ff, live_in;
   logic [IW-1:0]            i_ff, i_in;
   logic [IW-1:0]            j_ff, j_in;
   logic signed [COST_W-1:0] dist_ff [NODES];
   logic signed [COST_W-1:0] dist_in [NODES];
   logic signed [HOP_W-1:0]  route_ff [NODES];
   logic signed [HOP_W-1:0]  route_in [NODES];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_to_neighbor_ff, rsp_to_neighbor_in;
   logic [IDX_W-1:0]         rsp_adv_dest_ff, rsp_adv_dest_in;
   logic signed [COST_W-1:0] rsp_adv_cost_ff, rsp_adv_cost_in;
   logic signed [HOP_W-1:0]  rsp_next_hop_ff, rsp_next_hop_in;
   logic signed [COST_W-1:0] rsp_path_cost_ff, rsp_path_cost_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     item_ok;
   logic                     store_vec;
   logic                     run;
   logic                     csr_self_ok;
   logic signed [COST_W-1:0] req_cost_norm;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [COST_W-1:0] wr_data;
   logic [AW-1:0]            rd_addr_a;
   logic [AW-1:0]            rd_addr_b;
   logic signed [COST_W-1:0] link_cost;
   logic signed [COST_W-1:0] far_cost;

   relax_ctl_type            relax_ctl;
   logic signed [COST_W-1:0] best_cost;
   logic [IDX_W-1:0]         best_hop;

   logic                     commit;
   logic                     end_scan;
   logic                     dist_diff;
   logic [IW-1:0]            dist_sel;
   logic signed [COST_W-1:0] dist_cur;
   logic signed [HOP_W-1:0]  route_cur;
   logic                     live_cur;
   logic                     more_live;

   // ---------------------------------------------------------------------
   // Request decode. Requests that name a node outside the network, or that
   // arrive while the own node number is outside it, change nothing.
   // ---------------------------------------------------------------------
   always_comb begin
      accept        = start && (state_ff == ST_IDLE);
      item_ok       = ({1'b0, self_ff} < NODE_LIM) && ({1'b0, req_neighbor} < NODE_LIM)
                      && ((req_kind == KIND_LINK) || ({1'b0, req_entry_dest} < NODE_LIM));
      // A vector entry claiming to come from this node is not stored, but its
      // final-entry flag still starts a recompute.
      store_vec     = (req_kind == KIND_VECTOR) && (req_neighbor != self_ff);
      run           = item_ok && ((req_kind == KIND_LINK) ? recompute_ff : req_last_entry);
      req_cost_norm = req_cost[COST_W-1] ? NO_ROUTE : req_cost;
      csr_self_ok   = csr_write && (csr_index == CSR_SELF_INDEX)
                      && ({1'b0, csr_wdata[IDX_W-1:0]} < NODE_LIM);
   end

   // ---------------------------------------------------------------------
   // Cost-table write port. Reset writes the self entry of node zero; a new
   // node number writes its own self entry; requests write links or vectors.
   // ---------------------------------------------------------------------
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (reset) begin
         wr_en = 1'b1;
      end else if (csr_self_ok) begin
         wr_en   = 1'b1;
         wr_addr = {csr_wdata[IW-1:0], csr_wdata[IW-1:0]};
      end else if (accept && item_ok && ((req_kind == KIND_LINK) || store_vec)) begin
         wr_en   = 1'b1;
         wr_data = req_cost_norm;
         if (req_kind == KIND_LINK) begin
            wr_addr = {self_ff[IW-1:0], req_neighbor[IW-1:0]};
         end else begin
            wr_addr = {req_neighbor[IW-1:0], req_entry_dest[IW-1:0]};
         end
      end
   end

   // Port A reads the own link cost to the hop, port B what the hop
   // advertised for the destination.
   assign rd_addr_a = {self_ff[IW-1:0], h_ff};
   assign rd_addr_b = {h_ff, d_ff};

   dvr_cost_mem #(
      .AW (AW)
   ) u_cost_mem (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (link_cost),
      .rd_data_b (far_cost)
   );

   // ---------------------------------------------------------------------
   // The relaxation unit sees each destination and hop pair in the cycle after
   // its addresses were issued. The own hop never counts as a candidate.
   // ---------------------------------------------------------------------
   always_comb begin
      relax_ctl.step  = s1_valid_ff;
      relax_ctl.first = (s1_h_ff == '0);
      relax_ctl.skip  = (IDX_W'(s1_h_ff) == self_ff);
      relax_ctl.diag  = (s1_h_ff == s1_d_ff);
      relax_ctl.hop   = IDX_W'(s1_h_ff);
   end

   dvr_relax_unit u_relax_unit (
      .clock     (clock),
      .ctl       (relax_ctl),
      .link_cost (link_cost),
      .far_cost  (far_cost),
      .best_cost (best_cost),
      .best_hop  (best_hop)
   );

   // ---------------------------------------------------------------------
   // Route table lookup and broadcast bookkeeping.
   // ---------------------------------------------------------------------
   always_comb begin
      commit    = s1_valid_ff && (s1_h_ff == LAST_IDX) && (IDX_W'(s1_d_ff) != self_ff);
      end_scan  = s1_valid_ff && (s1_h_ff == LAST_IDX) && (s1_d_ff == LAST_IDX);
      dist_sel  = (state_ff == ST_SEND) ? j_ff : s1_d_ff;
      dist_cur  = dist_ff[dist_sel];
      route_cur = route_ff[dist_sel];
      dist_diff = commit && (dist_cur != best_cost);
      live_cur  = live_ff[i_ff];
      more_live = 1'b0;
      for (int k = 0; k < NODES; k++) begin
         if ((IW'(k) > i_ff) && live_ff[k]) begin
            more_live = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in           = state_ff;
      self_in            = self_ff;
      recompute_in       = recompute_ff;
      d_in               = d_ff;
      h_in               = h_ff;
      issue_in           = issue_ff;
      s1_valid_in        = 1'b0;
      s1_d_in            = s1_d_ff;
      s1_h_in            = s1_h_ff;
      changed_in         = changed_ff;
      live_in            = live_ff;
      i_in               = i_ff;
      j_in               = j_ff;
      dist_in            = dist_ff;
      route_in           = route_ff;
      rsp_valid_in       = 1'b0;
      rsp_to_neighbor_in = rsp_to_neighbor_ff;
      rsp_adv_dest_in    = rsp_adv_dest_ff;
      rsp_adv_cost_in    = rsp_adv_cost_ff;
      rsp_next_hop_in    = rsp_next_hop_ff;
      rsp_path_cost_in   = rsp_path_cost_ff;
      rsp_last_in        = rsp_last_ff;

      // Configuration. A new node number inside the network gets a zero path cost to itself.
      if (csr_write) begin
         case (csr_index)
            CSR_SELF_INDEX: begin
               self_in = csr_wdata[IDX_W-1:0];
               if (csr_self_ok) begin
                  dist_in[csr_wdata[IW-1:0]] = '0;
               end
            end
            CSR_RECOMPUTE: begin
               recompute_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && run) begin
               state_in    = ST_SCAN;
               d_in        = '0;
               h_in        = '0;
               issue_in    = 1'b1;
               changed_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            s1_valid_in = issue_ff;
            s1_d_in     = d_ff;
            s1_h_in     = h_ff;
            if (issue_ff) begin
               if (h_ff == LAST_IDX) begin
                  h_in = '0;
                  if (d_ff == LAST_IDX) begin
                     issue_in = 1'b0;
                  end else begin
                     d_in = d_ff + 1'b1;
                  end
               end else begin
                  h_in = h_ff + 1'b1;
               end
            end
            // Every pass reads the whole own row, so the live-neighbour mask
            // is rebuilt along the way.
            if (s1_valid_ff) begin
               live_in[s1_h_ff] = !link_cost[COST_W-1] && (IDX_W'(s1_h_ff) != self_ff);
            end
            if (commit) begin
               dist_in[s1_d_ff]  = best_cost;
               route_in[s1_d_ff] = best_cost[COST_W-1] ? NO_HOP : HOP_W'(best_hop);
               changed_in        = changed_ff || dist_diff;
            end
            if (end_scan) begin
               state_in = (changed_ff || dist_diff) ? ST_SEND : ST_IDLE;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_SEND: begin
            if (live_cur) begin
               rsp_valid_in       = 1'b1;
               rsp_to_neighbor_in = IDX_W'(i_ff);
               rsp_adv_dest_in    = IDX_W'(j_ff);
               rsp_next_hop_in    = route_cur;
               rsp_path_cost_in   = dist_cur;
               // Poison reverse: a route through the receiver is sent as
               // unreachable.
               rsp_adv_cost_in    = (route_cur == {1'b0, IDX_W'(i_ff)}) ? NO_ROUTE : dist_cur;
               rsp_last_in        = (j_ff == LAST_IDX) && !more_live;
               if (j_ff == LAST_IDX) begin
                  j_in = '0;
                  if (i_ff == LAST_IDX) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               j_in = '0;
               if (i_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         self_ff      <= '0;
         recompute_ff <= 1'b1;
         issue_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         changed_ff   <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         // Node zero reaches itself at no cost; everything else is unreachable.
         for (int k = 0; k < NODES; k++) begin
            dist_ff[k]  <= (k == 0) ? '0 : NO_ROUTE;
            route_ff[k] <= NO_HOP;
         end
      end else begin
         state_ff     <= state_in;
         self_ff      <= self_in;
         recompute_ff <= recompute_in;
         issue_ff     <= issue_in;
         s1_valid_ff  <= s1_valid_in;
         changed_ff   <= changed_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         dist_ff      <= dist_in;
         route_ff     <= route_in;
      end
      d_ff               <= d_in;
      h_ff               <= h_in;
      s1_d_ff            <= s1_d_in;
      s1_h_ff            <= s1_h_in;
      i_ff               <= i_in;
      j_ff               <= j_in;
      rsp_to_neighbor_ff <= rsp_to_neighbor_in;
      rsp_adv_dest_ff    <= rsp_adv_dest_in;
      rsp_adv_cost_ff    <= rsp_adv_cost_in;
      rsp_next_hop_ff    <= rsp_next_hop_in;
      rsp_path_cost_ff   <= rsp_path_cost_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_to_neighbor = rsp_to_neighbor_ff;
   assign rsp_adv_dest    = rsp_adv_dest_ff;
   assign rsp_adv_cost    = rsp_adv_cost_ff;
   assign rsp_next_hop    = rsp_next_hop_ff;
   assign rsp_path_cost   = rsp_path_cost_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
